// File: rtl/bfss_pkg.sv
`timescale 1ns / 1ps
package bfss_pkg;

  localparam int unsigned MAX_LEN_DEFAULT = 256;
  localparam int unsigned OPCODE_W        = 2;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QUEUE_PTR_W     = 1;
  localparam int unsigned QUEUE_CNT_W     = 2;

  typedef enum logic [OPCODE_W-1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_SEARCH  = 2'd2
  } bfss_cmd_e;

  typedef struct packed {
    bfss_cmd_e         kind;
    logic [CHAR_W-1:0] char_value;
  } bfss_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_CMP,
    ST_DONE
  } bfss_state_e;

endpackage

// File: rtl/bfss_front.sv
`timescale 1ns / 1ps
module bfss_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [bfss_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [bfss_pkg::CHAR_W-1:0]    char_value_i,
  output bfss_pkg::bfss_item_t           item_o,
  output logic                           item_valid_o,
  input  logic                           item_pop_i
);
  import bfss_pkg::*;

  bfss_item_t             entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   known_op;
  logic                   push;
  logic                   pop;
  bfss_item_t             new_item;

  // classify the opcode; the unused code is dropped here and never queued
  always_comb begin
    new_item.char_value = char_value_i;
    new_item.kind       = CMD_PATTERN;
    known_op            = 1'b1;
    case (opcode_i)
      CMD_PATTERN: new_item.kind = CMD_PATTERN;
      CMD_TEXT:    new_item.kind = CMD_TEXT;
      CMD_SEARCH:  new_item.kind = CMD_SEARCH;
      default:     known_op      = 1'b0;
    endcase
  end

  assign busy         = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push         = start && !busy && known_op;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// File: rtl/bfss_engine.sv
`timescale 1ns / 1ps
module bfss_engine #(
  parameter int unsigned MAX_LEN = bfss_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfss_pkg::bfss_item_t         item_i,
  input  logic                         item_valid_i,
  output logic                         item_pop_o,
  input  logic [bfss_pkg::CHAR_W-1:0]  start_position_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [bfss_pkg::CHAR_W-1:0]  match_position_o,
  output logic                         truncated_o
);
  import bfss_pkg::*;

  localparam int unsigned IW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = (CW > CHAR_W) ? CW : CHAR_W;
  localparam int unsigned SW = PW + 1;

  logic [CHAR_W-1:0] pat_mem [MAX_LEN];
  logic [CHAR_W-1:0] txt_mem [MAX_LEN];
  logic [CHAR_W-1:0] pat_rd_q, txt_rd_q;

  bfss_state_e       state_q, state_d;
  logic [PW-1:0]     p_q, p_d;
  logic [IW-1:0]     k_q, k_d;
  logic [CW-1:0]     pcnt_q, pcnt_d;
  logic [CW-1:0]     tcnt_q, tcnt_d;
  logic              rst_pat_q, rst_pat_d;
  logic              rst_txt_q, rst_txt_d;
  logic              ovf_q, ovf_d;
  logic              rvalid_q, rvalid_d;
  logic              found_q, found_d;
  logic [CHAR_W-1:0] pos_q, pos_d;
  logic              trunc_q, trunc_d;

  logic              pat_we, txt_we;
  logic [IW-1:0]     wr_addr;
  logic [CW-1:0]     base_cnt;
  logic [SW-1:0]     win_end;
  logic [SW-1:0]     next_end;
  logic [SW-1:0]     rd_sum;
  logic [IW-1:0]     pat_raddr, txt_raddr;

  assign rd_sum    = SW'(p_q) + SW'(k_q);
  assign txt_raddr = rd_sum[IW-1:0];
  assign pat_raddr = k_q;
  assign win_end   = SW'(p_q) + SW'(pcnt_q);
  assign next_end  = win_end + SW'(1);

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    k_d        = k_q;
    pcnt_d     = pcnt_q;
    tcnt_d     = tcnt_q;
    rst_pat_d  = rst_pat_q;
    rst_txt_d  = rst_txt_q;
    ovf_d      = ovf_q;
    rvalid_d   = 1'b0;
    found_d    = found_q;
    pos_d      = pos_q;
    trunc_d    = trunc_q;
    item_pop_o = 1'b0;
    pat_we     = 1'b0;
    txt_we     = 1'b0;
    base_cnt   = '0;
    wr_addr    = '0;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.kind)
            CMD_PATTERN: begin
              base_cnt  = rst_pat_q ? '0 : pcnt_q;
              wr_addr   = base_cnt[IW-1:0];
              rst_pat_d = 1'b0;
              pcnt_d    = base_cnt;
              if (base_cnt < CW'(MAX_LEN)) begin
                pat_we = 1'b1;
                pcnt_d = base_cnt + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_TEXT: begin
              base_cnt  = rst_txt_q ? '0 : tcnt_q;
              wr_addr   = base_cnt[IW-1:0];
              rst_txt_d = 1'b0;
              tcnt_d    = base_cnt;
              if (base_cnt < CW'(MAX_LEN)) begin
                txt_we = 1'b1;
                tcnt_d = base_cnt + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_SEARCH: begin
              p_d     = PW'(start_position_i);
              state_d = ST_SETUP;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        k_d = '0;
        if (pcnt_q == '0) begin
          // empty pattern matches at the start position
          found_d = 1'b1;
          pos_d   = p_q[CHAR_W-1:0];
          state_d = ST_DONE;
        end else if (win_end > SW'(tcnt_q)) begin
          found_d = 1'b0;
          pos_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (txt_rd_q == pat_rd_q) begin
          if (CW'(k_q) + CW'(1) == pcnt_q) begin
            found_d = 1'b1;
            pos_d   = p_q[CHAR_W-1:0];
            state_d = ST_DONE;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = ST_READ;
          end
        end else begin
          // slide the window on by one
          p_d = p_q + PW'(1);
          k_d = '0;
          if (next_end > SW'(tcnt_q)) begin
            found_d = 1'b0;
            pos_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_DONE: begin
        rvalid_d  = 1'b1;
        trunc_d   = ovf_q;
        ovf_d     = 1'b0;
        rst_pat_d = 1'b1;
        rst_txt_d = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      p_q       <= '0;
      k_q       <= '0;
      pcnt_q    <= '0;
      tcnt_q    <= '0;
      rst_pat_q <= 1'b1;
      rst_txt_q <= 1'b1;
      ovf_q     <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      k_q       <= k_d;
      pcnt_q    <= pcnt_d;
      tcnt_q    <= tcnt_d;
      rst_pat_q <= rst_pat_d;
      rst_txt_q <= rst_txt_d;
      ovf_q     <= ovf_d;
      rvalid_q  <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    pos_q   <= pos_d;
    trunc_q <= trunc_d;
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[wr_addr] <= item_i.char_value;
    end
    pat_rd_q <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      txt_mem[wr_addr] <= item_i.char_value;
    end
    txt_rd_q <= txt_mem[txt_raddr];
  end

  assign result_valid_o   = rvalid_q;
  assign found_o          = found_q;
  assign match_position_o = pos_q;
  assign truncated_o      = trunc_q;

endmodule

// File: rtl/brute_force_substring_search_top.sv
`timescale 1ns / 1ps
// Substring search over a stored pattern and text of up to MAX_LEN bytes each. Pattern and
// text bytes (opcode 0 and 1) go through a two-entry command queue; while no search is
// running, a stream of bytes is taken at one per cycle. A search (opcode 2) tries each
// window from start_position on and compares one byte pair at a time, as each
// comparison waits for the registered read of both byte stores (state READ, then CMP). busy
// rises while the queue is full. Each search gives one result, shown for exactly one cycle
// with result_valid_o; the receiver cannot stall it. start_position may be written only
// while the block is idle.
module brute_force_substring_search_top #(
  parameter int unsigned MAX_LEN = bfss_pkg::MAX_LEN_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [bfss_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [bfss_pkg::CHAR_W-1:0]  char_value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfss_pkg::CHAR_W-1:0]  cfg_start_position_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [bfss_pkg::CHAR_W-1:0]  match_position_o,
  output logic                         truncated_o
);
  import bfss_pkg::*;

  bfss_item_t        item;
  logic              item_valid;
  logic              item_pop;
  logic [CHAR_W-1:0] start_pos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      start_pos_q <= cfg_start_position_i;
    end
  end

  bfss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .char_value_i (char_value_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  bfss_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .item_valid_i     (item_valid),
    .item_pop_o       (item_pop),
    .start_position_i (start_pos_q),
    .result_valid_o   (result_valid_o),
    .found_o          (found_o),
    .match_position_o (match_position_o),
    .truncated_o      (truncated_o)
  );

`ifndef NO_ASSERTIONS
  // a search passes through SETUP and DONE before its result, so results never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (match_position_o == '0))
    else $error("miss reported with a nonzero position");

  // nothing leaves the queue unless something is in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("queue popped while empty");
`endif

endmodule
